@@ hw/rtl/bcdalu_pkg.sv @@
// Types and operation codes shared by the packed-BCD ALU.
`default_nettype none

package bcdalu_pkg;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_NEG  = 2'd3
	} op_t;

	localparam logic [7:0] NIBBLE_CARRY_MASK = 8'h88;
	localparam logic [8:0] DEC_ADJUST        = 9'h066;
	localparam logic [8:0] DEC_CARRY_MASK    = 9'h110;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] dest_byte;
		logic [7:0] source_byte;
		logic       init_extend;
		logic       init_zero;
	} in_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       flag_x;
		logic       flag_n;
		logic       flag_z;
		logic       flag_v;
		logic       flag_c;
	} out_t;

	// flags that carry over from one request to the next
	typedef struct packed {
		logic x;
		logic z;
	} state_t;

	// two marks (bits 7 and 3) expand to a correction of 6 per nibble
	function automatic logic [7:0] correction(input logic [7:0] marks);
		correction = {1'b0, marks[7], marks[7], 2'b00, marks[3], marks[3], 1'b0};
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bcd_alu_with_flags_top.sv @@
// Top level of the packed-BCD ALU with X/N/Z/V/C flags.
`default_nettype none

// Byte-wide packed-BCD ALU: load flags, add with extend, subtract with extend
// and negate with extend. One request is taken per clock cycle while the result
// side does not stall. The request is registered in req_s1, the BCD correction
// and flags are computed in one combinational pass, and the result is
// registered in result_q. The X and Z flags live in registers updated by that
// same pass, so the next request sees them without delay. BCD operations can
// only clear Z, never set it; only a load sets it. Stall on the result side
// propagates back to request_stall in the same cycle.
module bcd_alu_with_flags_top
	import bcdalu_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       request_valid,
	output logic      request_stall,
	input  wire in_t  request,
	output logic      result_valid,
	input  wire       result_stall,
	output out_t      result
);

	logic   valid_s1;
	in_t    req_s1;
	logic   valid_q;
	out_t   result_q;
	state_t state_q;
	state_t state_next;
	out_t   core_rsp;
	logic   advance;

	assign advance       = valid_s1 & (~valid_q | ~result_stall);
	assign request_stall = valid_s1 & ~advance;

	bcdalu_core u_core (
		.req        (req_s1),
		.state      (state_q),
		.rsp        (core_rsp),
		.next_state (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
			state_q  <= '0;
		end else begin
			if (!request_stall) begin
				valid_s1 <= request_valid;
			end
			if (advance) begin
				valid_q <= 1'b1;
				state_q <= state_next;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request_valid && !request_stall) begin
			req_s1 <= request;
		end
		if (advance) begin
			result_q <= core_rsp;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	a_carry_eq_extend: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (result_q.flag_c == result_q.flag_x))
		else $error("flag_c differs from flag_x");

	a_neg_is_msb: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (result_q.flag_n == result_q.result_byte[7]))
		else $error("flag_n differs from result bit 7");

	a_zero_never_set: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_t'(req_s1.operation) != OP_LOAD)) |-> (!state_next.z || state_q.z))
		else $error("Z set by a BCD operation");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		request_stall |-> (valid_s1 && valid_q && result_stall))
		else $error("request stalled with room available");

endmodule

`default_nettype wire

@@ hw/rtl/bcdalu_core.sv @@
// Combinational BCD add/subtract/negate with flag computation.
`default_nettype none

module bcdalu_core
	import bcdalu_pkg::*;
(
	input  wire in_t    req,
	input  wire state_t state,
	output out_t        rsp,
	output state_t      next_state
);

	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] ss;
	logic [7:0] add_bc;
	logic [8:0] adj;
	logic [8:0] dc_raw;
	logic [7:0] dc;
	logic [7:0] add_rr;
	logic       add_xc;
	logic       add_v;
	logic [7:0] dd;
	logic [7:0] sub_bc;
	logic [7:0] sub_rr;
	logic       sub_xc;
	logic       sub_v;
	logic [7:0] rr;
	logic       xc;
	logic       v;

	// negate is a subtract from zero
	always_comb begin
		if (op_t'(req.operation) == OP_NEG) begin
			a = 8'h00;
			b = req.dest_byte;
		end else begin
			a = req.dest_byte;
			b = req.source_byte;
		end
	end

	always_comb begin
		ss     = a + b + {7'd0, state.x};
		add_bc = ((a & b) | (~ss & a) | (~ss & b)) & NIBBLE_CARRY_MASK;
		adj    = {1'b0, ss} + DEC_ADJUST;
		dc_raw = (adj ^ {1'b0, ss}) & DEC_CARRY_MASK;
		dc     = dc_raw[8:1];
		add_rr = ss + correction(add_bc | dc);
		add_xc = add_bc[7] | (ss[7] & ~add_rr[7]);
		add_v  = ~ss[7] & add_rr[7];

		dd     = a - b - {7'd0, state.x};
		sub_bc = ((~a & b) | (dd & ~a) | (dd & b)) & NIBBLE_CARRY_MASK;
		sub_rr = dd - correction(sub_bc);
		sub_xc = sub_bc[7] | (~dd[7] & sub_rr[7]);
		sub_v  = dd[7] & ~sub_rr[7];
	end

	always_comb begin
		unique case (op_t'(req.operation))
			OP_LOAD: begin
				rr = 8'h00;
				xc = req.init_extend;
				v  = 1'b0;
			end
			OP_ADD: begin
				rr = add_rr;
				xc = add_xc;
				v  = add_v;
			end
			default: begin
				rr = sub_rr;
				xc = sub_xc;
				v  = sub_v;
			end
		endcase
	end

	always_comb begin
		next_state.x = xc;
		if (op_t'(req.operation) == OP_LOAD) begin
			next_state.z = req.init_zero;
		end else begin
			next_state.z = state.z & (rr == 8'h00);
		end
		rsp.result_byte = rr;
		rsp.flag_x      = xc;
		rsp.flag_n      = rr[7];
		rsp.flag_z      = next_state.z;
		rsp.flag_v      = v;
		rsp.flag_c      = xc;
	end

endmodule

`default_nettype wire
